/* hdl/pcso_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcso_pkg: shared types and constants
// Widths, register indexes and the divide unit request/response structs.
// ----------------------------------------------------------------------------
package pcso_pkg;

  localparam int PRIME_W   = 31;
  localparam int OFFSET_W  = 33;
  localparam int LAYER_W   = 5;
  localparam int COEF_W    = 34;
  localparam int CNT_W     = 6;
  localparam int LOW_W     = 24;
  localparam int CHAIN_W   = 5;
  localparam int EXT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int SHIFT_W   = 5;

  localparam int MAX_RESULTS        = 32;
  localparam int DEF_MAX_CHAIN      = 24;
  localparam int DEF_MAX_EXTENSIONS = 8;

  localparam logic [CHAIN_W-1:0] CHAIN_RESET = 5'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENSION_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENSION_LOW_INDEX = 2'd2;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic                 start;
    logic [PRIME_W-1:0]   dividend;
    logic [PRIME_W-1:0]   divisor;
    coef_t                acc;
    coef_t                coef;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [PRIME_W-1:0]   rem;
    coef_t                acc;
  } div_rsp_t;

endpackage
`default_nettype wire

/* hdl/pcso_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcso_if: request channels
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pcso_in_if;
  import pcso_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRIME_W-1:0] prime;
  logic [PRIME_W-1:0] residue;
  modport source (output valid, output prime, output residue, input ready);
  modport sink (input valid, input prime, input residue, output ready);
endinterface

interface pcso_out_if;
  import pcso_pkg::*;
  logic                valid;
  logic                ready;
  logic [LAYER_W-1:0]  layer_index;
  logic [OFFSET_W-1:0] first_kind_offset;
  logic [OFFSET_W-1:0] second_kind_offset;
  logic                last_layer;
  modport source (output valid, output layer_index, output first_kind_offset,
                  output second_kind_offset, output last_layer, input ready);
  modport sink (input valid, input layer_index, input first_kind_offset,
                input second_kind_offset, input last_layer, output ready);
endinterface

interface pcso_cfg_if;
  import pcso_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LOW_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/pcso_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcso_div: shared shift-subtract divide unit
// Computes dividend mod divisor and acc - quotient * coef, one quotient bit
// per cycle after aligning the divisor to the dividend.
// ----------------------------------------------------------------------------
module pcso_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pcso_pkg::div_req_t req_i,
  output pcso_pkg::div_rsp_t     rsp_o
);
  import pcso_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_ALIGN = 3'b010,
    D_SUB   = 3'b100
  } dstate_e;

  dstate_e             state_q, state_d;
  logic [PRIME_W-1:0]  rem_q, rem_d;
  logic [PRIME_W-1:0]  dvs_q, dvs_d;
  coef_t               sd_q, sd_d;
  coef_t               acc_q, acc_d;
  logic [SHIFT_W-1:0]  cnt_q, cnt_d;
  logic                done_q, done_d;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    sd_d    = sd_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          rem_d   = req_i.dividend;
          dvs_d   = req_i.divisor;
          sd_d    = req_i.coef;
          acc_d   = req_i.acc;
          cnt_d   = '0;
          state_d = D_ALIGN;
        end
      end
      D_ALIGN: begin
        // Grow the divisor while twice its value still fits under the dividend.
        if ({dvs_q, 1'b0} <= {1'b0, rem_q}) begin
          dvs_d = {dvs_q[PRIME_W-2:0], 1'b0};
          sd_d  = sd_q <<< 1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = D_SUB;
        end
      end
      D_SUB: begin
        if (dvs_q <= rem_q) begin
          rem_d = rem_q - dvs_q;
          acc_d = acc_q - sd_q;
        end
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          dvs_d = dvs_q >> 1;
          sd_d  = sd_q >>> 1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    sd_q  <= sd_d;
    acc_q <= acc_d;
  end

  assign rsp_o.busy = (state_q != D_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;
  assign rsp_o.acc  = acc_q;

endmodule
`default_nettype wire

/* hdl/prime_chain_sieve_offsets.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prime_chain_sieve_offsets: first-hit offset generator for a chain sieve
// Finds the modular inverse of the residue by extended Euclid on a shared
// divide unit, then emits two offsets per layer, halving modulo the prime.
// ----------------------------------------------------------------------------
// Channel  Dir   Payload                                         Handshake
// in_i     in    prime, residue                                  valid/ready
// out_o    out   layer_index, first/second_kind_offset, last     valid/ready
// cfg_i    in    index, data                                     valid/ready
//
// One request passes through setup on the divide unit (residue reduction,
// low index reduction, then one division per Euclid step); a prime below
// two skips setup. Each layer then passes through the layer state and the
// output state; a stalled result holds the layer loop.
// Input ready is high only while no request is in progress; the result
// register lets the next request enter while the last result waits.
// Reset clears control, sets chain length to CHAIN_RESET and clears config.
// ----------------------------------------------------------------------------
module prime_chain_sieve_offsets #(
  parameter int MAX_CHAIN      = pcso_pkg::DEF_MAX_CHAIN,
  parameter int MAX_EXTENSIONS = pcso_pkg::DEF_MAX_EXTENSIONS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pcso_in_if.sink   in_i,
  pcso_out_if.source out_o,
  pcso_cfg_if.sink  cfg_i
);
  import pcso_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RED   = 7'b0000010,
    S_LOWM  = 7'b0000100,
    S_EUC   = 7'b0001000,
    S_FIX   = 7'b0010000,
    S_LAYER = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CHAIN_W-1:0]  chain_length_q;
  logic [EXT_W-1:0]    extension_count_q;
  logic [LOW_W-1:0]    extension_low_index_q;

  logic [PRIME_W-1:0]  p_q, p_d;
  logic [PRIME_W-1:0]  r0_q, r0_d, r1_q, r1_d;
  coef_t               s1_q, s1_d;
  logic [LOW_W-1:0]    low_q, low_d;
  logic [LOW_W-1:0]    m_q, m_d;
  logic [LOW_W-1:0]    lowm_q, lowm_d;
  logic [OFFSET_W-1:0] lowpm_q, lowpm_d;
  logic [PRIME_W-1:0]  inv_q, inv_d;
  logic [PRIME_W-1:0]  cmp_q, cmp_d;
  logic                zero_q, zero_d;
  logic [CNT_W-1:0]    chain_q, chain_d;
  logic [CNT_W-1:0]    total_q, total_d;
  logic [CNT_W-1:0]    k_q, k_d;

  logic                out_valid_q;
  logic [LAYER_W-1:0]  out_layer_q;
  logic [OFFSET_W-1:0] out_first_q, out_second_q;
  logic                out_last_q;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                in_fire;
  logic                out_load;
  logic [CNT_W-1:0]    chain_eff, ext_eff, sum_eff, total_eff;
  logic                is_ext, is_last;
  logic [OFFSET_W-1:0] first_off, second_off, first_val, second_val;
  coef_t               s1_norm;
  logic [PRIME_W:0]    halve_sum;

  pcso_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_length_q        <= CHAIN_RESET;
      extension_count_q     <= '0;
      extension_low_index_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CHAIN_LENGTH:        chain_length_q        <= cfg_i.data[CHAIN_W-1:0];
        CFG_EXTENSION_COUNT:     extension_count_q     <= cfg_i.data[EXT_W-1:0];
        CFG_EXTENSION_LOW_INDEX: extension_low_index_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Layer counts, saturated to the supported ranges.
  always_comb begin
    if (chain_length_q == '0) begin
      chain_eff = CNT_W'(1);
    end else if (CNT_W'(chain_length_q) > CNT_W'(MAX_CHAIN)) begin
      chain_eff = CNT_W'(MAX_CHAIN);
    end else begin
      chain_eff = CNT_W'(chain_length_q);
    end
    if (CNT_W'(extension_count_q) > CNT_W'(MAX_EXTENSIONS)) begin
      ext_eff = CNT_W'(MAX_EXTENSIONS);
    end else begin
      ext_eff = CNT_W'(extension_count_q);
    end
    sum_eff   = chain_eff + ext_eff;
    total_eff = (sum_eff > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : sum_eff;
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // Layer values; extension layers are lifted above the low index.
  assign is_ext     = (k_q >= chain_q);
  assign is_last    = ((k_q + 1'b1) == total_q);
  assign first_off  = (inv_q >= PRIME_W'(m_q)) ? OFFSET_W'(lowm_q) : lowpm_q;
  assign second_off = (cmp_q >= PRIME_W'(m_q)) ? OFFSET_W'(lowm_q) : lowpm_q;

  always_comb begin
    if (zero_q) begin
      first_val  = '0;
      second_val = '0;
    end else if (is_ext) begin
      first_val  = OFFSET_W'(inv_q) + first_off;
      second_val = OFFSET_W'(cmp_q) + second_off;
    end else begin
      first_val  = OFFSET_W'(inv_q);
      second_val = OFFSET_W'(cmp_q);
    end
  end

  assign halve_sum = {1'b0, inv_q} + {1'b0, p_q};
  assign s1_norm   = s1_q[COEF_W-1] ? (s1_q + COEF_W'(p_q)) : s1_q;

  // Divide unit requests.
  always_comb begin
    div_req          = '0;
    div_req.dividend = r1_q;
    div_req.divisor  = p_q;
    div_req.acc      = s1_q;
    div_req.coef     = div_rsp.acc;
    case (state_q)
      S_IDLE: begin
        div_req.start    = in_fire && (in_i.prime > PRIME_W'(1));
        div_req.dividend = in_i.residue;
        div_req.divisor  = in_i.prime;
        div_req.acc      = '0;
        div_req.coef     = '0;
      end
      S_RED: begin
        div_req.start    = div_rsp.done && (div_rsp.rem != '0);
        div_req.dividend = PRIME_W'(low_q);
        div_req.acc      = '0;
        div_req.coef     = '0;
      end
      S_LOWM: begin
        div_req.start    = div_rsp.done && (r1_q > PRIME_W'(1));
        div_req.dividend = p_q;
        div_req.divisor  = r1_q;
        div_req.acc      = '0;
        div_req.coef     = COEF_W'(1);
      end
      S_EUC: begin
        div_req.start   = div_rsp.done && (div_rsp.rem > PRIME_W'(1));
        div_req.divisor = div_rsp.rem;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    s1_d    = s1_q;
    low_d   = low_q;
    m_d     = m_q;
    lowm_d  = lowm_q;
    lowpm_d = lowpm_q;
    inv_d   = inv_q;
    cmp_d   = cmp_q;
    zero_d  = zero_q;
    chain_d = chain_q;
    total_d = total_q;
    k_d     = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          p_d     = in_i.prime;
          low_d   = extension_low_index_q;
          chain_d = chain_eff;
          total_d = total_eff;
          k_d     = '0;
          inv_d   = '0;
          if (in_i.prime > PRIME_W'(1)) begin
            zero_d  = 1'b0;
            state_d = S_RED;
          end else begin
            zero_d  = 1'b1;
            state_d = S_LAYER;
          end
        end
      end
      S_RED: begin
        if (div_rsp.done) begin
          r1_d = div_rsp.rem;
          if (div_rsp.rem == '0) begin
            zero_d  = 1'b1;
            state_d = S_LAYER;
          end else begin
            state_d = S_LOWM;
          end
        end
      end
      S_LOWM: begin
        if (div_rsp.done) begin
          m_d    = div_rsp.rem[LOW_W-1:0];
          lowm_d = low_q - div_rsp.rem[LOW_W-1:0];
          r0_d   = p_q;
          s1_d   = COEF_W'(1);
          state_d = (r1_q > PRIME_W'(1)) ? S_EUC : S_FIX;
        end
      end
      S_EUC: begin
        if (div_rsp.done) begin
          r0_d = r1_q;
          r1_d = div_rsp.rem;
          s1_d = div_rsp.acc;
          if (div_rsp.rem <= PRIME_W'(1)) begin
            state_d = S_FIX;
          end
        end
      end
      S_FIX: begin
        inv_d   = s1_norm[PRIME_W-1:0];
        zero_d  = (s1_norm == '0);
        lowpm_d = OFFSET_W'(lowm_q) + OFFSET_W'(p_q);
        state_d = S_LAYER;
      end
      S_LAYER: begin
        cmp_d   = p_q - inv_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          inv_d   = inv_q[0] ? halve_sum[PRIME_W:1] : (inv_q >> 1);
          k_d     = k_q + 1'b1;
          state_d = is_last ? S_IDLE : S_LAYER;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      chain_q     <= '0;
      total_q     <= '0;
      zero_q      <= 1'b1;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      chain_q <= chain_d;
      total_q <= total_d;
      zero_q  <= zero_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    r0_q    <= r0_d;
    r1_q    <= r1_d;
    s1_q    <= s1_d;
    low_q   <= low_d;
    m_q     <= m_d;
    lowm_q  <= lowm_d;
    lowpm_q <= lowpm_d;
    inv_q   <= inv_d;
    cmp_q   <= cmp_d;
    if (out_load) begin
      out_layer_q  <= k_q[LAYER_W-1:0];
      out_first_q  <= first_val;
      out_second_q <= second_val;
      out_last_q   <= is_last;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.layer_index        = out_layer_q;
  assign out_o.first_kind_offset  = out_first_q;
  assign out_o.second_kind_offset = out_second_q;
  assign out_o.last_layer         = out_last_q;

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divide unit started while busy");

  a_euclid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EUC) |-> (r1_q < r0_q))
    else $error("Euclid remainders out of order");

  a_layer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (k_q < total_q))
    else $error("layer counter beyond layer total");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_last) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after last layer");
`endif

endmodule
`default_nettype wire
